/* hw/rtl/sscp_pkg.sv */
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared types and constants for the serial setting command parser.
// ----------------------------------------------------------------------------
package sscp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAN = 3'd0,
    CFG_ADDR = 3'd1,
    CFG_FLOW = 3'd2,
    CFG_PROT = 3'd3,
    CFG_DBG  = 3'd4
  } cfg_idx_e;

  // Pending command codes
  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_CHAN = 3'd1,
    CMD_ADDR = 3'd2,
    CMD_FLOW = 3'd3,
    CMD_PROT = 3'd4,
    CMD_DBG  = 3'd5
  } cmd_e;

  // Session status codes
  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_NOCHANGE = 2'd2,
    ST_ERRORS   = 2'd3
  } status_e;

  // Input operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Error bit positions
  localparam int ERR_UNKNOWN_CMD  = 0;
  localparam int ERR_OUT_OF_RANGE = 1;
  localparam int ERR_UNKNOWN_CHAR = 2;

  // Character codes
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Digit limits per command
  localparam logic [3:0] LIM_CHAN = 4'd3;
  localparam logic [3:0] LIM_DBG  = 4'd7;
  localparam logic [3:0] LIM_FLAG = 4'd1;

  // Stored settings, also the default register set
  typedef struct packed {
    logic [1:0] channel_offset;
    logic       address_select;
    logic       flow_control;
    logic       protect_mode;
    logic [2:0] debug_bits;
  } settings_t;

  // One input transaction
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] error_bits;
    logic       soft_valid;
    settings_t  settings;
  } out_item_t;

endpackage

/* hw/rtl/sscp_if.sv */
// ----------------------------------------------------------------------------
// sscp_if
// Valid/ready stream interfaces for parser input bytes and parser results.
// ----------------------------------------------------------------------------
interface sscp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface sscp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] error_bits;
  logic       soft_valid;
  logic [1:0] channel_offset;
  logic       address_select;
  logic       flow_control;
  logic       protect_mode;
  logic [2:0] debug_bits;

  modport source (
    output valid, output status, output error_bits, output soft_valid,
    output channel_offset, output address_select, output flow_control,
    output protect_mode, output debug_bits, input ready
  );
  modport sink (
    input valid, input status, input error_bits, input soft_valid,
    input channel_offset, input address_select, input flow_control,
    input protect_mode, input debug_bits, output ready
  );
endinterface

/* hw/rtl/sscp_cfg.sv */
// ----------------------------------------------------------------------------
// sscp_cfg
// Default setting registers, written through a plain index/data port.
// ----------------------------------------------------------------------------
module sscp_cfg
  import sscp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output settings_t             dflt_o
);

  settings_t dflt_d, dflt_q;

  // Register decode; unknown indexes are dropped
  always_comb begin
    dflt_d = dflt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHAN: dflt_d.channel_offset = cfg_wdata_i[1:0];
        CFG_ADDR: dflt_d.address_select = cfg_wdata_i[0];
        CFG_FLOW: dflt_d.flow_control   = cfg_wdata_i[0];
        CFG_PROT: dflt_d.protect_mode   = cfg_wdata_i[0];
        CFG_DBG:  dflt_d.debug_bits     = cfg_wdata_i[2:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else begin
      dflt_q <= dflt_d;
    end
  end

  assign dflt_o = dflt_q;

endmodule

/* hw/rtl/sscp_parser.sv */
// ----------------------------------------------------------------------------
// sscp_parser
// Session state and the per-byte parse step; emits the post-step result.
// ----------------------------------------------------------------------------
module sscp_parser
  import sscp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  settings_t dflt_i,
  output out_item_t result_o
);

  cmd_e      cmd_d, cmd_q;
  logic [2:0] err_d, err_q;
  logic      any_d, any_q;
  logic      sv_d, sv_q;
  settings_t set_d, set_q;
  status_e   status;
  logic      is_digit;
  logic [3:0] digit;
  logic [3:0] limit;

  assign is_digit = (item_i.rx_byte >= CH_ZERO) && (item_i.rx_byte <= CH_NINE);
  // low nibble of an ASCII digit is its value
  assign digit    = item_i.rx_byte[3:0];

  always_comb begin
    case (cmd_q)
      CMD_CHAN: limit = LIM_CHAN;
      CMD_DBG:  limit = LIM_DBG;
      default:  limit = LIM_FLAG;
    endcase
  end

  // Parse step
  always_comb begin
    cmd_d  = cmd_q;
    err_d  = err_q;
    any_d  = any_q;
    sv_d   = sv_q;
    set_d  = set_q;
    status = ST_PENDING;
    if (item_i.op == OP_RESTART) begin
      cmd_d = CMD_NONE;
      err_d = '0;
      any_d = 1'b0;
      sv_d  = 1'b0;
      set_d = dflt_i;
    end else if (cmd_q == CMD_NONE) begin
      unique case (item_i.rx_byte)
        CH_C: cmd_d = CMD_CHAN;
        CH_A: cmd_d = CMD_ADDR;
        CH_H: cmd_d = CMD_FLOW;
        CH_P: cmd_d = CMD_PROT;
        CH_D: cmd_d = CMD_DBG;
        CH_DASH: begin
          // session end: commit or reject
          if (err_q == '0) begin
            sv_d   = 1'b1;
            status = any_q ? ST_ACCEPTED : ST_NOCHANGE;
          end else begin
            sv_d   = 1'b0;
            status = ST_ERRORS;
          end
        end
        default: err_d[ERR_UNKNOWN_CMD] = 1'b1;
      endcase
    end else if (is_digit) begin
      if (digit > limit) begin
        err_d[ERR_OUT_OF_RANGE] = 1'b1;
      end else begin
        case (cmd_q)
          CMD_CHAN: set_d.channel_offset = digit[1:0];
          CMD_ADDR: set_d.address_select = digit[0];
          CMD_FLOW: set_d.flow_control   = digit[0];
          CMD_PROT: set_d.protect_mode   = digit[0];
          default:  set_d.debug_bits     = digit[2:0];
        endcase
        any_d = 1'b1;
      end
      cmd_d = CMD_NONE;
    end else begin
      // command stays pending
      err_d[ERR_UNKNOWN_CHAR] = 1'b1;
    end
  end

  // Session registers advance once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_NONE;
      err_q <= '0;
      any_q <= 1'b0;
      sv_q  <= 1'b0;
      set_q <= '0;
    end else if (step_i) begin
      cmd_q <= cmd_d;
      err_q <= err_d;
      any_q <= any_d;
      sv_q  <= sv_d;
      set_q <= set_d;
    end
  end

  assign result_o.status     = status;
  assign result_o.error_bits = err_d;
  assign result_o.soft_valid = sv_d;
  assign result_o.settings   = set_d;

endmodule

/* hw/rtl/serial_setting_command_parser_core.sv */
// ----------------------------------------------------------------------------
// serial_setting_command_parser_core
// Path: the input transaction is held in the input register, then the parse
// step writes the result register, which drives the result transaction.
// Throughput: one byte per cycle unless the result stream stalls; the session
// registers update once per byte.
// Reset: asynchronous, active low; session cleared, defaults all zero.
// ----------------------------------------------------------------------------
module serial_setting_command_parser_core
  import sscp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sscp_in_if.sink               in_i,
  sscp_out_if.source            out_o
);

  settings_t dflt;
  out_item_t result;
  in_item_t  in_item_q;
  out_item_t out_item_q;
  logic      in_vld_d, in_vld_q;
  logic      out_vld_d, out_vld_q;
  logic      advance;
  logic      in_take;

  sscp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dflt_o      (dflt)
  );

  sscp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .dflt_i   (dflt),
    .result_o (result)
  );

  // Handshake control
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.op      <= in_i.op;
      in_item_q.rx_byte <= in_i.rx_byte;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_item_q.status;
  assign out_o.error_bits     = out_item_q.error_bits;
  assign out_o.soft_valid     = out_item_q.soft_valid;
  assign out_o.channel_offset = out_item_q.settings.channel_offset;
  assign out_o.address_select = out_item_q.settings.address_select;
  assign out_o.flow_control   = out_item_q.settings.flow_control;
  assign out_o.protect_mode   = out_item_q.settings.protect_mode;
  assign out_o.debug_bits     = out_item_q.settings.debug_bits;

endmodule

/* tb/tb_serial_setting_command_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_serial_setting_command_parser_core
// Self-checking bench for the settings-session parser. Byte and restart
// transactions go in over the input stream and every report is checked
// field by field against a cycle-free session predictor. Directed sessions
// cover each command, the error flags and default reload. Random sessions
// follow, mostly well formed, with default registers rewritten between
// phases and random idle on both stream sides.
// ----------------------------------------------------------------------------
module tb_serial_setting_command_parser_core;
  import sscp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_GAP        = 13;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 305;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sscp_in_if  in_if ();
  sscp_out_if out_if ();

  serial_setting_command_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted parser state and default registers
  cmd_e       pend_cmd;
  logic [2:0] err_flags;
  logic       any_stored;
  logic       sw_valid;
  settings_t  stored;
  settings_t  dflt;

  out_item_t  predicted_reports[$];
  bit         steady_flow;

  int unsigned items_sent;
  int unsigned restarts_sent;
  int unsigned reports_seen;
  int unsigned regs_written;
  int unsigned mismatches;
  int unsigned n_accepted;
  int unsigned n_nochange;
  int unsigned n_errors;
  int unsigned idle_cycles;

  function automatic int unsigned draw_gap();
    if (steady_flow) begin
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] max_digit(input cmd_e c);
    if (c == CMD_CHAN) begin
      return {4'd0, LIM_CHAN};
    end
    if (c == CMD_DBG) begin
      return {4'd0, LIM_DBG};
    end
    return {4'd0, LIM_FLAG};
  endfunction

  function automatic logic [7:0] cmd_letter(input cmd_e c);
    case (c)
      CMD_CHAN: return CH_C;
      CMD_ADDR: return CH_A;
      CMD_FLOW: return CH_H;
      CMD_PROT: return CH_P;
      default:  return CH_D;
    endcase
  endfunction

  function automatic void restart_session();
    pend_cmd   = CMD_NONE;
    err_flags  = 3'b000;
    any_stored = 1'b0;
    sw_valid   = 1'b0;
    stored     = dflt;
  endfunction

  // Advance the predicted session by one transaction, return the report
  function automatic out_item_t advance_session(input logic op, input logic [7:0] b);
    out_item_t  r;
    status_e    st;
    logic [7:0] v;
    st = ST_PENDING;
    if (op == OP_RESTART) begin
      restart_session();
    end else if (pend_cmd == CMD_NONE) begin
      case (b)
        CH_C: pend_cmd = CMD_CHAN;
        CH_A: pend_cmd = CMD_ADDR;
        CH_H: pend_cmd = CMD_FLOW;
        CH_P: pend_cmd = CMD_PROT;
        CH_D: pend_cmd = CMD_DBG;
        CH_DASH: begin
          sw_valid = (err_flags == 3'b000);
          if (err_flags != 3'b000) begin
            st = ST_ERRORS;
          end else if (any_stored) begin
            st = ST_ACCEPTED;
          end else begin
            st = ST_NOCHANGE;
          end
        end
        default: err_flags[ERR_UNKNOWN_CMD] = 1'b1;
      endcase
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      v = b - CH_ZERO;
      if (v > max_digit(pend_cmd)) begin
        err_flags[ERR_OUT_OF_RANGE] = 1'b1;
      end else begin
        case (pend_cmd)
          CMD_CHAN: stored.channel_offset = v[1:0];
          CMD_ADDR: stored.address_select = v[0];
          CMD_FLOW: stored.flow_control   = v[0];
          CMD_PROT: stored.protect_mode   = v[0];
          default:  stored.debug_bits     = v[2:0];
        endcase
        any_stored = 1'b1;
      end
      pend_cmd = CMD_NONE;
    end else begin
      // non-digit while a command waits for its value
      err_flags[ERR_UNKNOWN_CHAR] = 1'b1;
    end
    r.status     = st;
    r.error_bits = err_flags;
    r.soft_valid = sw_valid;
    r.settings   = stored;
    return r;
  endfunction

  // Send one transaction; valid stays high for a back-to-back follower
  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted_reports.push_back(advance_session(op, b));
    items_sent++;
    if (op == OP_RESTART) begin
      restarts_sent++;
    end
  endtask

  task automatic send_restart();
    send_item(OP_RESTART, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending and let every outstanding report come back
  task automatic drain_parser();
    in_if.valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write enable is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CHAN: dflt.channel_offset = data[1:0];
      CFG_ADDR: dflt.address_select = data[0];
      CFG_FLOW: dflt.flow_control   = data[0];
      CFG_PROT: dflt.protect_mode   = data[0];
      CFG_DBG:  dflt.debug_bits     = data[2:0];
      default:  ;
    endcase
    regs_written++;
  endtask

  // Write all default registers with junk in unused bits, plus a stray index
  task automatic load_defaults(input settings_t s);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_CHAN, {junk[0], s.channel_offset});
    write_reg(CFG_ADDR, {junk[1:0], s.address_select});
    write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
    write_reg(CFG_FLOW, {junk[2:1], s.flow_control});
    write_reg(CFG_PROT, {junk[1], junk[2], s.protect_mode});
    write_reg(CFG_DBG, s.debug_bits);
    cfg_we_i <= 1'b0;
  endtask

  // An empty session, then every command with its top value, then a clean end
  task automatic test_basic_session();
    send_restart();
    send_item(OP_BYTE, CH_DASH);
    send_item(OP_BYTE, CH_C);
    send_item(OP_BYTE, CH_ZERO + 8'd3);
    send_item(OP_BYTE, CH_A);
    send_item(OP_BYTE, CH_ZERO + 8'd1);
    send_item(OP_BYTE, CH_H);
    send_item(OP_BYTE, CH_ZERO + 8'd1);
    send_item(OP_BYTE, CH_P);
    send_item(OP_BYTE, CH_ZERO + 8'd1);
    send_item(OP_BYTE, CH_D);
    send_item(OP_BYTE, CH_ZERO + 8'd7);
    send_item(OP_BYTE, CH_DASH);
  endtask

  // Unknown command, dash while a command waits, out-of-range digits
  task automatic test_error_flags();
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_C);
    send_item(OP_BYTE, CH_DASH);
    send_item(OP_BYTE, CH_ZERO + 8'd4);
    send_item(OP_BYTE, CH_A);
    send_item(OP_BYTE, CH_NINE);
    send_item(OP_BYTE, CH_DASH);
  endtask

  // Defaults written mid-session only show up after the next restart
  task automatic test_default_reload();
    drain_parser();
    load_defaults('1);
    send_item(OP_BYTE, CH_DASH);
    send_restart();
    send_item(OP_BYTE, CH_DASH);
    send_item(OP_BYTE, CH_D);
    send_item(OP_BYTE, CH_ZERO);
    send_item(OP_BYTE, CH_DASH);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return cmd_letter(cmd_e'($urandom_range(1, 5)));
      2: return CH_ZERO + 8'($urandom_range(0, 9));
      default: begin
        case ($urandom_range(0, 4))
          0: return CH_DASH;
          1: return CH_ZERO - 8'd1;
          2: return CH_NINE + 8'd1;
          3: return 8'h00;
          default: return 8'hFF;
        endcase
      end
    endcase
  endfunction

  // One random session: mostly well formed, sometimes plain noise
  task automatic run_session();
    int unsigned n;
    cmd_e        c;
    logic [7:0]  lim;
    if ($urandom_range(0, 7) == 0) begin
      steady_flow = !steady_flow;
    end
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 3) != 0) begin
        send_restart();
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_BYTE, noise_byte());
        end
        c   = cmd_e'($urandom_range(1, 5));
        lim = max_digit(c);
        send_item(OP_BYTE, cmd_letter(c));
        if ($urandom_range(0, 7) == 0) begin
          send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0) begin
          send_item(OP_BYTE, CH_ZERO + 8'($urandom_range(lim + 1, 9)));
        end else begin
          send_item(OP_BYTE, CH_ZERO + 8'($urandom_range(0, lim)));
        end
      end
      send_item(OP_BYTE, CH_DASH);
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          send_restart();
        end else begin
          send_item(OP_BYTE, noise_byte());
        end
      end
    end
  endtask

  // Random phases; defaults all zero, all ones, then random
  task automatic test_random_sessions();
    int unsigned phase_start;
    logic [7:0]  raw;
    settings_t   s;
    for (int p = 0; p < PHASES; p++) begin
      drain_parser();
      raw = 8'($urandom);
      s   = raw;
      if (p == 0) begin
        s = '0;
      end else if (p == 1) begin
        s = '1;
      end
      load_defaults(s);
      send_restart();
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        run_session();
      end
    end
  endtask

  // Result-side ready: random stall per transaction, none in steady stretches
  initial begin : drive_ready
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Compare every report with the oldest prediction
  always @(posedge clk_i) begin : check_reports
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      reports_seen++;
      if (predicted_reports.size() == 0) begin
        $display("%0t: report with nothing predicted, status %0d errors %0d",
                 $time, out_if.status, out_if.error_bits);
        mismatches++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", want.status, out_if.status);
        check_field("error_bits", want.error_bits, out_if.error_bits);
        check_field("soft_valid", want.soft_valid, out_if.soft_valid);
        check_field("channel_offset", want.settings.channel_offset,
                    out_if.channel_offset);
        check_field("address_select", want.settings.address_select,
                    out_if.address_select);
        check_field("flow_control", want.settings.flow_control, out_if.flow_control);
        check_field("protect_mode", want.settings.protect_mode, out_if.protect_mode);
        check_field("debug_bits", want.settings.debug_bits, out_if.debug_bits);
        case (status_e'(want.status))
          ST_ACCEPTED: n_accepted++;
          ST_NOCHANGE: n_nochange++;
          ST_ERRORS:   n_errors++;
          default:     ;
        endcase
      end
    end
  end

  // Watchdog: cycles without any transaction or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles, %0d reports outstanding",
                 $time, WATCHDOG_LIMIT, predicted_reports.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.op      = OP_BYTE;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    idle_cycles   = 0;
    steady_flow   = 1'b0;
    dflt          = '0;
    restart_session();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_session();
    test_error_flags();
    test_default_reload();
    test_random_sessions();

    drain_parser();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_reports.size() != 0) begin
      $display("%0t: %0d predicted reports never arrived", $time, predicted_reports.size());
      mismatches++;
    end

    $display("Sent %0d transactions (%0d restarts), checked %0d reports, %0d register writes",
             items_sent, restarts_sent, reports_seen, regs_written);
    $display("Session ends: %0d accepted, %0d no change, %0d with errors; %0d mismatches",
             n_accepted, n_nochange, n_errors, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
